### sv/uuid_gen_pkg.sv
// ----------------------------------------------------------------------------
// uuid_gen_pkg
// Widths, constants and register codes shared by the time-based UUID
// generator and its channel interfaces.
// ----------------------------------------------------------------------------
package uuid_gen_pkg;

  localparam int SEC_W   = 32;
  localparam int USEC_W  = 20;
  localparam int SEQ_W   = 14;
  localparam int NODE_W  = 48;
  localparam int TICK_W  = 4;
  localparam int HALF_W  = 64;
  localparam int STAMP_W = 60;
  localparam int PROD_W  = 56;   // seconds * 10^7 fits here
  localparam int LOW_W   = 24;   // micros * 10 + adjustment fits here
  localparam int ADDR_W  = 4;
  localparam int DATA_W  = 64;

  localparam logic [TICK_W-1:0]  ADJUST_LIMIT     = 4'd10;
  localparam logic [23:0]        TICKS_PER_SECOND = 24'd10000000;
  // 100 ns ticks from the Gregorian epoch to the 1970 epoch
  localparam logic [STAMP_W-1:0] EPOCH_OFFSET     = 60'h1B21DD213814000;
  localparam logic [3:0]         UUID_VERSION     = 4'h1;
  localparam logic [1:0]         UUID_VARIANT     = 2'b10;

  // Register index, taken from paddr bit 3 (registers on 8-byte strides)
  typedef enum logic [0:0] {
    REG_NODE_ADDRESS  = 1'b0,
    REG_SEQUENCE_SEED = 1'b1
  } cfg_reg_t;

endpackage

### sv/uuid_gen_req_if.sv
// ----------------------------------------------------------------------------
// uuid_gen_req_if
// Request channel: one wall-clock reading per item.
// ----------------------------------------------------------------------------
interface uuid_gen_req_if import uuid_gen_pkg::*; ();

  logic              valid;
  logic              ready;
  logic [SEC_W-1:0]  now_seconds;
  logic [USEC_W-1:0] now_micros;

  modport source (output valid, output now_seconds, output now_micros, input ready);
  modport sink   (input valid, input now_seconds, input now_micros, output ready);

endinterface

### sv/uuid_gen_rsp_if.sv
// ----------------------------------------------------------------------------
// uuid_gen_rsp_if
// Response channel: one UUID per item, as two 64-bit big-endian halves.
// ----------------------------------------------------------------------------
interface uuid_gen_rsp_if import uuid_gen_pkg::*; ();

  logic              valid;
  logic              ready;
  logic [HALF_W-1:0] uuid_high;
  logic [HALF_W-1:0] uuid_low;

  modport source (output valid, output uuid_high, output uuid_low, input ready);
  modport sink   (input valid, input uuid_high, input uuid_low, output ready);

endinterface

### sv/time_based_uuid_generator.sv
// ----------------------------------------------------------------------------
// time_based_uuid_generator
// Version-1 UUID generator: wall-clock reading in, time-based UUID out.
// ----------------------------------------------------------------------------
// Usage:
//   req  - valid/ready channel, one item = (now_seconds, now_micros).
//   rsp  - valid/ready channel, one item = (uuid_high, uuid_low).
//   APB  - node_address at 0x0, sequence_seed at 0x8 (64-bit data).
//          Write only while the block is idle.
// Throughput: one request per cycle unless rsp is held off. Four register
//   stages (input, clock sequence update, 32x24 multiply, final add/format)
//   each hold one item, in that order; the last one drives rsp.
// A request that repeats the last reading once the sub-microsecond adjust
//   has reached 10 produces no UUID and leaves the state alone; the
//   requester retries with a later time.
// Reset: all stages empty, first-request flag clear, clock sequence and
//   adjust at zero, both config registers at zero.
// Stall: when rsp is held off, the pipeline keeps filling; req.ready drops
//   only once every stage holds an item.
// ----------------------------------------------------------------------------
module time_based_uuid_generator
  import uuid_gen_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  uuid_gen_req_if.sink        req,
  uuid_gen_rsp_if.source      rsp,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ADDR_W-1:0]   paddr,
  input  logic [DATA_W-1:0]   pwdata,
  output logic [DATA_W-1:0]   prdata,
  output logic                pready
);

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [NODE_W-1:0] node_address;
  logic [SEQ_W-1:0]  sequence_seed;
  logic              cfg_wr;
  cfg_reg_t          cfg_sel;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_sel = cfg_reg_t'(paddr[3]);

  always_ff @(posedge clk) begin
    if (rst) begin
      node_address  <= '0;
      sequence_seed <= '0;
    end else if (cfg_wr) begin
      unique case (cfg_sel)
        REG_NODE_ADDRESS:  node_address  <= pwdata[NODE_W-1:0];
        REG_SEQUENCE_SEED: sequence_seed <= pwdata[SEQ_W-1:0];
        default: ;
      endcase
    end
  end

  // Reads return the register at aligned addresses, zero elsewhere
  always_comb begin
    prdata = '0;
    if (paddr[2:0] == 3'b000) begin
      unique case (cfg_sel)
        REG_NODE_ADDRESS:  prdata = DATA_W'(node_address);
        REG_SEQUENCE_SEED: prdata = DATA_W'(sequence_seed);
        default:           prdata = '0;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Pipeline flow control: a stage loads when it is empty or its item moves
  // --------------------------------------------------------------------------
  logic a_valid, b_valid, c_valid, out_valid;
  logic rdy_a, rdy_b, rdy_c, rdy_d;

  assign rdy_d     = !out_valid || rsp.ready;
  assign rdy_c     = !c_valid || rdy_d;
  assign rdy_b     = !b_valid || rdy_c;
  assign rdy_a     = !a_valid || rdy_b;
  assign req.ready = rdy_a;

  // --------------------------------------------------------------------------
  // Stage A: input register
  // --------------------------------------------------------------------------
  logic [SEC_W-1:0]  a_sec;
  logic [USEC_W-1:0] a_usec;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (rdy_a) begin
      a_valid <= req.valid;
    end
    if (rdy_a && req.valid) begin
      a_sec  <= req.now_seconds;
      a_usec <= req.now_micros;
    end
  end

  // --------------------------------------------------------------------------
  // Stage B: clock sequence / adjust update against the last reading
  // --------------------------------------------------------------------------
  logic                      started;
  logic [SEC_W-1:0]          last_sec;
  logic [USEC_W-1:0]         last_usec;
  logic [TICK_W-1:0]         sub_tick;
  logic [SEQ_W-1:0]          clk_seq;

  logic                      started_next;
  logic [TICK_W-1:0]         sub_tick_next;
  logic [SEQ_W-1:0]          clk_seq_next;
  logic                      take_reading;
  logic                      emit;
  logic                      adv_b;
  logic [SEC_W+USEC_W-1:0]   now_key;
  logic [SEC_W+USEC_W-1:0]   last_key;
  logic [LOW_W-1:0]          low_term;

  assign now_key  = {a_sec, a_usec};
  assign last_key = {last_sec, last_usec};
  assign adv_b    = a_valid && rdy_b;

  always_comb begin
    started_next  = 1'b1;
    sub_tick_next = '0;
    clk_seq_next  = clk_seq;
    take_reading  = 1'b1;
    emit          = 1'b1;
    priority if (!started) begin
      clk_seq_next = sequence_seed;
    end else if (now_key < last_key) begin
      // clock went backwards
      clk_seq_next = clk_seq + SEQ_W'(1);
    end else if (now_key == last_key) begin
      take_reading = 1'b0;
      if (sub_tick >= ADJUST_LIMIT) begin
        sub_tick_next = sub_tick;
        emit          = 1'b0;
      end else begin
        sub_tick_next = sub_tick + TICK_W'(1);
      end
    end else begin
      clk_seq_next = clk_seq;
    end
  end

  // micros * 10 + adjust
  assign low_term = {1'b0, a_usec, 3'b000} + {3'b000, a_usec, 1'b0}
                  + LOW_W'(sub_tick_next);

  logic [SEC_W-1:0] b_sec;
  logic [LOW_W-1:0] b_low;
  logic [SEQ_W-1:0] b_seq;

  always_ff @(posedge clk) begin
    if (rst) begin
      started   <= 1'b0;
      last_sec  <= '0;
      last_usec <= '0;
      sub_tick  <= '0;
      clk_seq   <= '0;
      b_valid   <= 1'b0;
    end else begin
      if (rdy_b) begin
        b_valid <= a_valid && emit;
      end
      if (adv_b) begin
        started  <= started_next;
        sub_tick <= sub_tick_next;
        clk_seq  <= clk_seq_next;
        if (take_reading) begin
          last_sec  <= a_sec;
          last_usec <= a_usec;
        end
      end
    end
    if (adv_b) begin
      b_sec <= a_sec;
      b_low <= low_term;
      b_seq <= clk_seq_next;
    end
  end

  // --------------------------------------------------------------------------
  // Stage C: seconds * 10^7, low part folded with the epoch offset
  // --------------------------------------------------------------------------
  logic [PROD_W-1:0]  c_prod;
  logic [STAMP_W-1:0] c_low;
  logic [SEQ_W-1:0]   c_seq;

  always_ff @(posedge clk) begin
    if (rst) begin
      c_valid <= 1'b0;
    end else if (rdy_c) begin
      c_valid <= b_valid;
    end
    if (rdy_c && b_valid) begin
      // 32-bit seconds times a 24-bit constant
      c_prod <= PROD_W'(b_sec) * PROD_W'(TICKS_PER_SECOND);
      c_low  <= EPOCH_OFFSET + STAMP_W'(b_low);
      c_seq  <= b_seq;
    end
  end

  // --------------------------------------------------------------------------
  // Stage D: final timestamp, UUID field layout, output register
  // --------------------------------------------------------------------------
  logic [STAMP_W-1:0] stamp;
  logic [HALF_W-1:0]  uuid_high;
  logic [HALF_W-1:0]  uuid_low;

  assign stamp = STAMP_W'(c_prod) + c_low;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (rdy_d) begin
      out_valid <= c_valid;
    end
    if (rdy_d && c_valid) begin
      // low time word : mid time : version : high time bits
      uuid_high <= {stamp[31:0], stamp[47:32], UUID_VERSION, stamp[59:48]};
      // variant : clock sequence : node
      uuid_low  <= {UUID_VARIANT, c_seq, node_address};
    end
  end

  assign rsp.valid     = out_valid;
  assign rsp.uuid_high = uuid_high;
  assign rsp.uuid_low  = uuid_low;

`ifndef SYNTHESIS
  // adjust never runs past its limit
  a_tick_limit: assert property (@(posedge clk) disable iff (rst)
    sub_tick <= ADJUST_LIMIT)
    else $error("sub_tick above limit");

  // before the first request the sequence state is untouched
  a_idle_state: assert property (@(posedge clk) disable iff (rst)
    !started |-> (sub_tick == '0) && (clk_seq == '0))
    else $error("state changed before first request");

  // an exhausted repeat reading is dropped and leaves the adjust as it was
  a_exhausted_drop: assert property (@(posedge clk) disable iff (rst)
    (adv_b && started && (now_key == last_key) && (sub_tick == ADJUST_LIMIT))
    |=> !b_valid && (sub_tick == ADJUST_LIMIT))
    else $error("exhausted request produced a UUID");
`endif

endmodule
